// ----- rtl/adl_pkg.sv -----
// Shared types, constants and modular helpers for the Adler-32 checksum unit.
// No dependencies.
package adl_pkg;

    localparam int unsigned DEFAULT_LANES = 8;
    localparam int unsigned FIELD_BYTES   = 8;
    localparam int unsigned DEFAULT_QUEUE_DEPTH = 4;

    localparam logic [16:0] ADLER_MOD = 17'd65521;
    // 2^16 mod 65521
    localparam logic [4:0]  FOLD_FACTOR = 5'd15;

    // One pre-digested word handed from the front end to the back end
    typedef struct packed {
        logic        start;
        logic [15:0] seed_one;
        logic [15:0] seed_two;
        logic [3:0]  count;
        logic [10:0] sum_a;
        logic [13:0] sum_b;
        logic        last;
    } adl_work_t;

    // Reduce a value below 2^20 modulo 65521: fold the high bits, then one subtract
    function automatic logic [15:0] adl_fold(input logic [19:0] x);
        logic [17:0] t;
        t = {2'b00, x[15:0]} + {9'd0, 9'(x[19:16]) * 9'(FOLD_FACTOR)};
        if (t >= {1'b0, ADLER_MOD})
            t = t - {1'b0, ADLER_MOD};
        return t[15:0];
    endfunction

    // Reduce one 16-bit seed half modulo 65521
    function automatic logic [15:0] adl_reduce_half(input logic [15:0] h);
        logic [16:0] t;
        t = {1'b0, h};
        if (t >= ADLER_MOD)
            t = t - ADLER_MOD;
        return t[15:0];
    endfunction

endpackage

// ----- rtl/adl_front.sv -----
// Front end: clamps the byte count, reduces the seed and forms the plain and
// position-weighted byte sums of one input word. Depends on adl_pkg.
module adl_front
    import adl_pkg::*;
#(
    parameter int unsigned LANES = DEFAULT_LANES
)
(
    input  logic        start_req,
    input  logic [31:0] seed,
    input  logic [63:0] data_bytes,
    input  logic [3:0]  byte_count,
    input  logic        last,
    output adl_work_t   work
);

    localparam int unsigned EFF_LANES = (LANES < FIELD_BYTES) ? LANES : FIELD_BYTES;
    localparam logic [3:0]  EFF_MAX   = 4'(EFF_LANES);

    logic [3:0] cnt;

    assign cnt = (byte_count > EFF_MAX) ? EFF_MAX : byte_count;

    // Byte k, when valid, adds to sum two once for each byte from k to the end
    always_comb
    begin
        logic [10:0] acc_a;
        logic [13:0] acc_b;
        logic [3:0]  weight;
        acc_a = '0;
        acc_b = '0;
        weight = '0;
        for (int k = 0; k < EFF_LANES; k++)
        begin
            if (4'(k) < cnt)
            begin
                weight = cnt - 4'(k);
                acc_a = acc_a + {3'd0, data_bytes[8*k +: 8]};
                acc_b = acc_b + {2'd0, 12'(data_bytes[8*k +: 8]) * 12'(weight)};
            end
        end
        work.start    = start_req;
        work.seed_one = adl_reduce_half(seed[15:0]);
        work.seed_two = adl_reduce_half(seed[31:16]);
        work.count    = cnt;
        work.sum_a    = acc_a;
        work.sum_b    = acc_b;
        work.last     = last;
    end

endmodule

// ----- rtl/adl_queue.sv -----
// Short register queue between the front and back ends.
// Depends on adl_pkg.
module adl_queue
    import adl_pkg::*;
#(
    parameter int unsigned DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  adl_work_t wr_data,
    output logic      full,
    input  logic      rd_en,
    output logic      rd_valid,
    output adl_work_t rd_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    adl_work_t        store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full     = (count_reg == DEPTH_C);
    assign rd_valid = (count_reg != '0);
    assign rd_data  = store_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            store_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- rtl/adl_back.sv -----
// Back end: holds the running sums, applies one queued word per cycle while the
// output register is free or drained, and keeps the result there. Depends on adl_pkg.
module adl_back
    import adl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  adl_work_t   in_work,
    output logic        in_take,
    output logic        out_valid,
    input  logic        out_take,
    output logic [31:0] checksum,
    output logic        final_res
);

    logic [15:0] sum_one_reg, sum_one_next;
    logic [15:0] sum_two_reg, sum_two_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] checksum_reg;
    logic        final_reg;
    logic [15:0] base_one, base_two;
    logic [19:0] two_raw;

    // Advance whenever the output register is free or being drained
    assign in_take = in_valid && (!out_valid_reg || out_take);

    assign base_one = in_work.start ? in_work.seed_one : sum_one_reg;
    assign base_two = in_work.start ? in_work.seed_two : sum_two_reg;

    // n bytes add n copies of the starting sum one to sum two, plus the weighted bytes
    assign two_raw = {4'd0, base_two} + (20'(base_one) * 20'(in_work.count))
                     + {6'd0, in_work.sum_b};

    assign sum_one_next = adl_fold({4'd0, base_one} + {9'd0, in_work.sum_a});
    assign sum_two_next = adl_fold(two_raw);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_take)
            out_valid_next = 1'b1;
        else if (out_take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_one_reg   <= 16'd1;
            sum_two_reg   <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_take)
            begin
                sum_one_reg <= sum_one_next;
                sum_two_reg <= sum_two_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            checksum_reg <= {sum_two_next, sum_one_next};
            final_reg    <= in_work.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign checksum  = checksum_reg;
    assign final_res = final_reg;

endmodule

// ----- rtl/adler32_checksum_unit.sv -----
// Top level of the Adler-32 checksum unit: front end, work queue, back end.
// Depends on adl_pkg, adl_front, adl_queue, adl_back.
//
//  channel  | handshake         | words
//  ---------+-------------------+--------------------------------------------
//  input    | push / full       | start_req, seed, data_bytes, byte_count, last
//  result   | empty / pop       | checksum, final_res
//
// One word per cycle sustained while pop drains each result; a taken word is
// written into the queue, then moved into the output register when the back
// end takes it. The rate is set by the back end's sum update, which closes its
// loop through the sum registers.
// Reset sets sum one to 1 and sum two to 0 and empties the queue at once.
// A stalled result side fills the queue, then raises full.
module adler32_checksum_unit
    import adl_pkg::*;
#(
    parameter int unsigned LANES       = DEFAULT_LANES,
    parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        start_req,
    input  logic [31:0] seed,
    input  logic [63:0] data_bytes,
    input  logic [3:0]  byte_count,
    input  logic        last,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] checksum,
    output logic        final_res
);

    adl_work_t front_work;
    adl_work_t queue_work;
    logic      queue_valid;
    logic      queue_take;
    logic      result_valid;

    adl_front #(
        .LANES (LANES)
    ) u_front (
        .start_req  (start_req),
        .seed       (seed),
        .data_bytes (data_bytes),
        .byte_count (byte_count),
        .last       (last),
        .work       (front_work)
    );

    adl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_data  (front_work),
        .full     (full),
        .rd_en    (queue_take),
        .rd_valid (queue_valid),
        .rd_data  (queue_work)
    );

    adl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (queue_valid),
        .in_work   (queue_work),
        .in_take   (queue_take),
        .out_valid (result_valid),
        .out_take  (pop),
        .checksum  (checksum),
        .final_res (final_res)
    );

    assign empty = !result_valid;

endmodule
